// File: rtl/self_organizing_count_list_macros.svh
// Assertion macros for the self-organizing count list.
// Each macro takes a label, the clock, the active-low reset, an antecedent
// and a consequent.
`ifndef SELF_ORGANIZING_COUNT_LIST_MACROS_SVH
`define SELF_ORGANIZING_COUNT_LIST_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define SOLC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("solc assertion failed");

// Next-cycle implication
`define SOLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("solc assertion failed");

`else

`define SOLC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SOLC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/solc_pkg.sv
package solc_pkg;

    // Field widths
    localparam int KEY_W = 32;
    localparam int CNT_W = 32;
    localparam int POS_W = 10;
    localparam int LEN_W = 11;

    // Config port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_ACTIVE_LENGTH = 1'b0;   // register index, paddr[2]
    localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

    // Saturation value of a hit count
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEARCH,
        ST_HIT,
        ST_SWAP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clearing;
        logic busy;
    } t_ctrl_status;

endpackage

// File: rtl/solc_key_if.sv
// Lookup key channel
interface solc_key_if;
    logic                       valid;
    logic                       ready;
    logic [solc_pkg::KEY_W-1:0] key;

    modport source (output valid, output key, input ready);
    modport sink (input valid, input key, output ready);
endinterface

// File: rtl/solc_res_if.sv
// Lookup result channel
interface solc_res_if;
    logic                       valid;
    logic                       ready;
    logic [solc_pkg::POS_W-1:0] position;
    logic                       found;

    modport source (output valid, output position, output found, input ready);
    modport sink (input valid, input position, input found, output ready);
endinterface

// File: rtl/solc_ram.sv
// Simple dual-port RAM, one write and one registered read per cycle
module solc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/solc_regs.sv
// APB register file: active_length
module solc_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [solc_pkg::APB_AW-1:0]        paddr,
    input  logic [solc_pkg::APB_DW-1:0]        pwdata,
    output logic [solc_pkg::APB_DW-1:0]        prdata,
    output logic                               pready,
    output logic [solc_pkg::LEN_W-1:0]         o_active_length
);

    logic [solc_pkg::LEN_W-1:0] r_active_length;
    logic                       sel_len;

    // Register index is the word address
    assign sel_len = (paddr[2] == solc_pkg::REG_ACTIVE_LENGTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_length <= solc_pkg::LEN_RESET;
        end else if (psel && penable && pwrite && sel_len) begin
            r_active_length <= pwdata[solc_pkg::LEN_W-1:0];
        end
    end

    // Read back, zero outside the register list
    always_comb begin
        prdata = '0;
        if (sel_len) begin
            prdata = {{(solc_pkg::APB_DW - solc_pkg::LEN_W){1'b0}}, r_active_length};
        end
    end

    assign pready          = 1'b1;
    assign o_active_length = r_active_length;

endmodule

// File: rtl/solc_ctrl.sv
// Search sequencer: clears the list RAM, scans it, bumps the hit count and
// swaps with the entry in front when the count overtakes it.
module solc_ctrl #(
    parameter int LIST_DEPTH = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [solc_pkg::LEN_W-1:0]  i_active_length,
    solc_key_if.sink                    i_key_ch,
    solc_res_if.source                  o_res_ch,
    output solc_pkg::t_ctrl_status      o_status
);

    localparam int AW = $clog2(LIST_DEPTH);
    localparam int LW = (AW + 1 > solc_pkg::LEN_W) ? AW + 1 : solc_pkg::LEN_W;
    localparam int KW = solc_pkg::KEY_W;
    localparam int CW = solc_pkg::CNT_W;
    localparam int DW = KW + CW;
    localparam logic [AW-1:0] LAST_ADDR = AW'(LIST_DEPTH - 1);

    // Control state
    solc_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_clr_addr, n_clr_addr;
    logic             r_issuing, n_issuing;
    logic             r_rd_pend, n_rd_pend;
    logic             r_out_valid, n_out_valid;

    // Payload
    logic [KW-1:0]               r_key, n_key;
    logic [AW-1:0]               r_last, n_last;
    logic [AW-1:0]               r_iss_addr, n_iss_addr;
    logic [AW-1:0]               r_rd_addr, n_rd_addr;
    logic [DW-1:0]               r_prev_data, n_prev_data;
    logic [DW-1:0]               r_hit_data, n_hit_data;
    logic [AW-1:0]               r_hit_addr, n_hit_addr;
    logic [AW-1:0]               r_pos, n_pos;
    logic                        r_found, n_found;
    logic [solc_pkg::POS_W-1:0]  r_out_pos, n_out_pos;
    logic                        r_out_found, n_out_found;

    // RAM port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;
    logic          ram_re;
    logic [DW-1:0] ram_rdata;

    // Datapath helpers
    logic [LW-1:0] len_ext;
    logic [LW-1:0] len_m1;
    logic [AW-1:0] last_idx;
    logic          match;
    logic [CW-1:0] hit_cnt;
    logic [CW-1:0] new_cnt;
    logic [CW-1:0] prev_cnt;
    logic          do_swap;
    logic [31:0]   pos_wide;

    // Entry layout: {count, key}
    solc_ram #(
        .WIDTH (DW),
        .DEPTH (LIST_DEPTH)
    ) u_list_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_iss_addr),
        .o_rdata (ram_rdata)
    );

    // Last searched index: zero length searches the front, long length clamps
    assign len_ext = LW'(i_active_length);
    assign len_m1  = len_ext - LW'(1);
    always_comb begin
        if (len_ext == '0) begin
            last_idx = '0;
        end else if (len_ext >= LW'(LIST_DEPTH)) begin
            last_idx = LAST_ADDR;
        end else begin
            last_idx = len_m1[AW-1:0];
        end
    end

    assign match    = r_rd_pend && (ram_rdata[KW-1:0] == r_key);
    assign hit_cnt  = r_hit_data[DW-1:KW];
    assign prev_cnt = r_prev_data[DW-1:KW];
    assign new_cnt  = (hit_cnt == solc_pkg::CNT_MAX) ? hit_cnt : hit_cnt + CW'(1);
    assign do_swap  = (r_hit_addr != '0) && (new_cnt > prev_cnt);
    assign pos_wide = 32'(r_pos);

    // Next state and RAM control
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_issuing   = r_issuing;
        n_rd_pend   = r_rd_pend;
        n_out_valid = r_out_valid;
        n_key       = r_key;
        n_last      = r_last;
        n_iss_addr  = r_iss_addr;
        n_rd_addr   = r_rd_addr;
        n_prev_data = r_prev_data;
        n_hit_data  = r_hit_data;
        n_hit_addr  = r_hit_addr;
        n_pos       = r_pos;
        n_found     = r_found;
        n_out_pos   = r_out_pos;
        n_out_found = r_out_found;
        ram_we      = 1'b0;
        ram_waddr   = r_hit_addr;
        ram_wdata   = {new_cnt, r_key};
        ram_re      = 1'b0;

        // Output register drains on its beat
        if (o_res_ch.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            solc_pkg::ST_CLEAR: begin
                // Entry i gets key i, count zero
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = {{CW{1'b0}}, KW'(r_clr_addr)};
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = solc_pkg::ST_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + AW'(1);
                end
            end

            solc_pkg::ST_IDLE: begin
                if (i_key_ch.valid) begin
                    n_key      = i_key_ch.key;
                    n_last     = last_idx;
                    n_iss_addr = '0;
                    n_issuing  = 1'b1;
                    n_rd_pend  = 1'b0;
                    n_state    = solc_pkg::ST_SEARCH;
                end
            end

            solc_pkg::ST_SEARCH: begin
                // Issue side: one read per cycle up to the last index
                if (r_issuing) begin
                    ram_re    = 1'b1;
                    n_rd_pend = 1'b1;
                    n_rd_addr = r_iss_addr;
                    if (r_iss_addr == r_last) begin
                        n_issuing = 1'b0;
                    end else begin
                        n_iss_addr = r_iss_addr + AW'(1);
                    end
                end else begin
                    n_rd_pend = 1'b0;
                end
                // Compare side: data for r_rd_addr
                if (match) begin
                    n_hit_data = ram_rdata;
                    n_hit_addr = r_rd_addr;
                    n_issuing  = 1'b0;
                    n_rd_pend  = 1'b0;
                    n_state    = solc_pkg::ST_HIT;
                end else if (r_rd_pend) begin
                    n_prev_data = ram_rdata;
                    if (r_rd_addr == r_last) begin
                        n_found   = 1'b0;
                        n_pos     = '0;
                        n_issuing = 1'b0;
                        n_rd_pend = 1'b0;
                        n_state   = solc_pkg::ST_DONE;
                    end
                end
            end

            solc_pkg::ST_HIT: begin
                // Write the bumped entry, one slot forward on overtake
                ram_we  = 1'b1;
                n_found = 1'b1;
                if (do_swap) begin
                    ram_waddr = r_hit_addr - AW'(1);
                    n_pos     = r_hit_addr - AW'(1);
                    n_state   = solc_pkg::ST_SWAP;
                end else begin
                    ram_waddr = r_hit_addr;
                    n_pos     = r_hit_addr;
                    n_state   = solc_pkg::ST_DONE;
                end
            end

            solc_pkg::ST_SWAP: begin
                // Displaced entry moves back one slot
                ram_we    = 1'b1;
                ram_waddr = r_hit_addr;
                ram_wdata = r_prev_data;
                n_state   = solc_pkg::ST_DONE;
            end

            solc_pkg::ST_DONE: begin
                if (!r_out_valid || o_res_ch.ready) begin
                    n_out_valid = 1'b1;
                    n_out_pos   = pos_wide[solc_pkg::POS_W-1:0];
                    n_out_found = r_found;
                    n_state     = solc_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = solc_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= solc_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_issuing   <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_issuing   <= n_issuing;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_last      <= n_last;
        r_iss_addr  <= n_iss_addr;
        r_rd_addr   <= n_rd_addr;
        r_prev_data <= n_prev_data;
        r_hit_data  <= n_hit_data;
        r_hit_addr  <= n_hit_addr;
        r_pos       <= n_pos;
        r_found     <= n_found;
        r_out_pos   <= n_out_pos;
        r_out_found <= n_out_found;
    end

    assign i_key_ch.ready    = (r_state == solc_pkg::ST_IDLE);
    assign o_res_ch.valid    = r_out_valid;
    assign o_res_ch.position = r_out_pos;
    assign o_res_ch.found    = r_out_found;

    assign o_status.clearing = (r_state == solc_pkg::ST_CLEAR);
    assign o_status.busy     = (r_state != solc_pkg::ST_IDLE);

endmodule

// File: rtl/self_organizing_count_list.sv
// Self-organizing key list with hit counts and transpose on overtake.
// Key channel (i_key_ch): one 32-bit key per beat. Result channel
// (o_res_ch): position of the key after any swap and a found flag; position
// is zero on a miss. Exactly one result beat per key beat, in order.
// Config: APB register active_length at byte 0 sets how many positions
// are searched from the front; write it only while the block is idle.
// A search reads the list from the front until the key matches or the last
// searched position has been read; a hit then writes the bumped entry, and
// on a swap the displaced entry as well, before the result is registered.
// One key is worked on at a time; the scan reads one list entry per cycle
// from a single list RAM.
// Reset: the list RAM is rewritten entry by entry (key i, count zero),
// during which no key is accepted.
// Stall: a finished result sits in an output register; the next key is
// taken meanwhile and its search runs, and it waits at the end only if the
// previous result still has not been taken.
`include "self_organizing_count_list_macros.svh"

module self_organizing_count_list #(
    parameter int LIST_DEPTH = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [solc_pkg::APB_AW-1:0]        paddr,
    input  logic [solc_pkg::APB_DW-1:0]        pwdata,
    output logic [solc_pkg::APB_DW-1:0]        prdata,
    output logic                               pready,
    solc_key_if.sink                           i_key_ch,
    solc_res_if.source                         o_res_ch
);

    logic [solc_pkg::LEN_W-1:0] active_length;
    solc_pkg::t_ctrl_status     ctrl_status;

    // Config registers
    solc_regs u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_active_length (active_length)
    );

    // Search sequencer with list RAM
    solc_ctrl #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_active_length (active_length),
        .i_key_ch        (i_key_ch),
        .o_res_ch        (o_res_ch),
        .o_status        (ctrl_status)
    );

    // Checks
    `SOLC_ASSERT_IMPL(a_busy_not_ready, i_clk, i_rst_n, ctrl_status.busy, !i_key_ch.ready)
    `SOLC_ASSERT_IMPL(a_clear_no_result, i_clk, i_rst_n, ctrl_status.clearing, !o_res_ch.valid)
    `SOLC_ASSERT_IMPL(a_miss_pos_zero, i_clk, i_rst_n, o_res_ch.valid && !o_res_ch.found, o_res_ch.position == '0)
    `SOLC_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_key_ch.valid && i_key_ch.ready, ctrl_status.busy)

endmodule

// File: tb/sv/tb_self_organizing_count_list.sv
module tb_self_organizing_count_list;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 1024;
    localparam int LONG_HOLD = 400;
    localparam logic [solc_pkg::APB_AW-1:0] ADDR_ACTIVE_LENGTH =
        {solc_pkg::REG_ACTIVE_LENGTH, 2'b00};

    typedef struct packed {
        logic [solc_pkg::POS_W-1:0] position;
        logic                       found;
    } t_lookup_result;

    // One directed lookup; typed rows carry their own expected result
    typedef struct {
        logic [solc_pkg::KEY_W-1:0] key;
        bit                         typed;
        logic [solc_pkg::POS_W-1:0] position;
        logic                       found;
    } t_lookup_row;

    // One random phase: register word, idling, item count, pressure points
    typedef struct {
        logic [solc_pkg::APB_DW-1:0] len_word;
        int                          gap_pct;
        int                          stall_pct;
        int                          items;
        int                          hold_at;
        int                          pause_at;
    } t_phase;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [solc_pkg::APB_AW-1:0] paddr;
    logic [solc_pkg::APB_DW-1:0] pwdata;
    logic [solc_pkg::APB_DW-1:0] prdata;
    logic pready;

    solc_key_if key_ch ();
    solc_res_if res_ch ();

    self_organizing_count_list #(
        .LIST_DEPTH (DEPTH)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .i_key_ch (key_ch),
        .o_res_ch (res_ch)
    );

    always #4 i_clk = ~i_clk;

    // Shadow of the list: keys, hit counts and the length register
    logic [solc_pkg::KEY_W-1:0] key_list [DEPTH];
    logic [solc_pkg::CNT_W-1:0] hit_cnt [DEPTH];
    logic [solc_pkg::LEN_W-1:0] len_reg;

    t_lookup_result expected_results [$];
    int fail_count = 0;
    int cfg_fail_count = 0;
    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int holds_started = 0;
    int hold_left = 0;

    t_lookup_row directed_rows [16] = '{
        '{32'd0,          1'b1, 10'd0,    1'b1},  // front hit
        '{32'd1,          1'b1, 10'd1,    1'b1},  // equal counts, stays
        '{32'd1,          1'b1, 10'd0,    1'b1},  // overtakes front
        '{32'd1023,       1'b1, 10'd1022, 1'b1},  // last entry, moves up
        '{32'd1024,       1'b1, 10'd0,    1'b0},  // just past the keys
        '{32'hFFFF_FFFF,  1'b1, 10'd0,    1'b0},
        '{32'h8000_0000,  1'b1, 10'd0,    1'b0},
        '{32'h5555_5555,  1'b1, 10'd0,    1'b0},
        '{32'hAAAA_AAAA,  1'b1, 10'd0,    1'b0},
        '{32'd0,          1'b0, 10'd0,    1'b0},
        '{32'd0,          1'b0, 10'd0,    1'b0},
        '{32'd1022,       1'b0, 10'd0,    1'b0},
        '{32'd1023,       1'b0, 10'd0,    1'b0},
        '{32'd1023,       1'b0, 10'd0,    1'b0},
        '{32'd512,        1'b0, 10'd0,    1'b0},
        '{32'd1,          1'b0, 10'd0,    1'b0}
    };

    t_phase phases [9] = '{
        '{32'd16,         0,  0,  80,  -1, -1},
        '{32'd0,          67, 0,  40,  -1, -1},  // zero length acts as one
        '{32'd1,          0,  67, 40,  -1, -1},
        '{32'd2047,       24, 24, 60,  -1, -1},  // clamps to full depth
        '{32'd2,          0,  0,  40,  -1, 20},
        '{32'd1024,       67, 0,  60,  -1, -1},
        '{32'd300,        0,  67, 60,  -1, -1},
        '{32'hFFFF_F808,  24, 24, 80,  -1, -1},  // upper bits dropped
        '{32'd64,         0,  0,  100, 5,  -1}
    };

    function automatic void list_reset();
        for (int i = 0; i < DEPTH; i++) begin
            key_list[i] = solc_pkg::KEY_W'(i);
            hit_cnt[i] = '0;
        end
        len_reg = solc_pkg::LEN_RESET;
    endfunction

    function automatic int search_len();
        int n;
        n = int'(len_reg);
        if (n == 0) n = 1;
        if (n > DEPTH) n = DEPTH;
        return n;
    endfunction

    // Count the hit and let the entry overtake the one in front
    function automatic t_lookup_result list_lookup(input logic [solc_pkg::KEY_W-1:0] k);
        t_lookup_result r;
        logic [solc_pkg::KEY_W-1:0] tk;
        logic [solc_pkg::CNT_W-1:0] tc;
        int n;
        n = search_len();
        r = '0;
        for (int i = 0; i < n; i++) begin
            if (key_list[i] == k) begin
                if (hit_cnt[i] != solc_pkg::CNT_MAX) hit_cnt[i] = hit_cnt[i] + 1'b1;
                r.found = 1'b1;
                r.position = solc_pkg::POS_W'(i);
                if (i > 0 && hit_cnt[i] > hit_cnt[i-1]) begin
                    tk = key_list[i-1];
                    tc = hit_cnt[i-1];
                    key_list[i-1] = key_list[i];
                    hit_cnt[i-1] = hit_cnt[i];
                    key_list[i] = tk;
                    hit_cnt[i] = tc;
                    r.position = solc_pkg::POS_W'(i - 1);
                end
                return r;
            end
        end
        return r;
    endfunction

    // Mostly hits near the front, some deep hits, misses and edge keys
    function automatic logic [solc_pkg::KEY_W-1:0] pick_key();
        int n;
        int front;
        int sel;
        n = search_len();
        front = (n < 24) ? n : 24;
        sel = $urandom_range(99);
        if (sel < 55) return key_list[$urandom_range(front - 1, 0)];
        if (sel < 70) return key_list[$urandom_range(n - 1, 0)];
        if (sel < 80 && n < DEPTH) return key_list[$urandom_range(DEPTH - 1, n)];
        if (sel < 95) return $urandom;
        case ($urandom_range(4))
            0: return '1;
            1: return 32'h8000_0000;
            2: return 32'd1023;
            3: return 32'd1024;
            default: return '0;
        endcase
    endfunction

    task automatic send_lookup(input t_lookup_row row);
        t_lookup_result r;
        while ($urandom_range(99) < send_gap_pct) begin
            key_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        key_ch.valid <= 1'b1;
        key_ch.key <= row.key;
        do @(posedge i_clk); while (!key_ch.ready);
        r = list_lookup(row.key);
        if (row.typed) begin
            r.position = row.position;
            r.found = row.found;
        end
        expected_results.push_back(r);
    endtask

    // Stop offering keys until every result is back
    task automatic wait_drained();
        key_ch.valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    task automatic apb_access(input logic wr, input logic [solc_pkg::APB_DW-1:0] wdata,
                              output logic [solc_pkg::APB_DW-1:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= ADDR_ACTIVE_LENGTH;
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic check_length_reg();
        logic [solc_pkg::APB_DW-1:0] rd;
        apb_access(1'b0, '0, rd);
        if (rd !== solc_pkg::APB_DW'(len_reg)) begin
            $error("active_length: expected %0d, got %0d", len_reg, rd);
            cfg_fail_count++;
        end
    endtask

    task automatic set_length(input logic [solc_pkg::APB_DW-1:0] word);
        logic [solc_pkg::APB_DW-1:0] rd;
        apb_access(1'b1, word, rd);
        len_reg = word[solc_pkg::LEN_W-1:0];
        check_length_reg();
    endtask

    // Result side: random stalls plus one long hold when requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (hold_requests != holds_started) begin
                holds_started = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        t_lookup_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_results.size() == 0) begin
                $error("result beat with nothing expected: position %0d found %0d",
                       res_ch.position, res_ch.found);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (res_ch.position !== want.position) begin
                    $error("position: expected %0d, got %0d", want.position,
                           res_ch.position);
                    fail_count++;
                end
                if (res_ch.found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, res_ch.found);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        t_lookup_row row;
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        key_ch.valid <= 1'b0;
        key_ch.key <= '0;
        list_reset();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_length_reg();

        // Directed lookups from the reset list
        foreach (directed_rows[i]) send_lookup(directed_rows[i]);

        // Random phases, each under its own length and idling
        row.typed = 1'b0;
        row.position = '0;
        row.found = 1'b0;
        foreach (phases[p]) begin
            wait_drained();
            send_gap_pct = 0;
            recv_stall_pct = 0;
            set_length(phases[p].len_word);
            send_gap_pct = phases[p].gap_pct;
            recv_stall_pct = phases[p].stall_pct;
            for (int i = 0; i < phases[p].items; i++) begin
                if (i == phases[p].hold_at) hold_requests++;
                if (i == phases[p].pause_at) wait_drained();
                row.key = pick_key();
                send_lookup(row);
            end
        end

        // Drain, then watch for stray beats
        key_ch.valid <= 1'b0;
        send_gap_pct = 0;
        recv_stall_pct = 0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DEPTH + 16) @(posedge i_clk);
        if (fail_count == 0 && cfg_fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #30_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: self_organizing_count_list.f
+incdir+rtl
rtl/solc_pkg.sv
rtl/solc_key_if.sv
rtl/solc_res_if.sv
rtl/solc_ram.sv
rtl/solc_regs.sv
rtl/solc_ctrl.sv
rtl/self_organizing_count_list.sv
tb/sv/tb_self_organizing_count_list.sv
